>>> rtl/vertex_normal_running_average_top_macros.svh
// Assertion macros for the vertex normal averaging top level.
`ifndef VERTEX_NORMAL_RUNNING_AVERAGE_TOP_MACROS_SVH
`define VERTEX_NORMAL_RUNNING_AVERAGE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VNRA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VNRA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vnra_pkg.sv
// Types and constants for the vertex normal running average block.
package vnra_pkg;

    localparam int IDX_W    = 12;
    localparam int COORD_W  = 32;
    localparam int NRM_W    = 16;
    localparam int CNT_W    = 16;
    localparam int EDGE_W   = 33;
    localparam int PROD_W   = 66;
    localparam int CROSS_W  = 67;
    localparam int SCALED_W = 30;
    localparam int SQ_W     = 62;
    localparam int ROOT_W   = 31;
    localparam int REM_W    = 33;
    localparam int FNUM_W   = 47;
    localparam int FQ_W     = 16;
    localparam int FACE_W   = 17;
    localparam int DIV_W    = 17;
    localparam int BNUM_W   = 18;
    localparam int BDEN_W   = 34;
    localparam int BQ_W     = 17;
    localparam int BLEND_W  = 18;
    localparam int STEP_W   = 5;
    localparam int ENTRY_W  = 3 * NRM_W + CNT_W;

    // Unit length in Q1.15 is 2^15; the face scale 2 * 32768 is a shift by 16.
    localparam int ONE_SHIFT = 15;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic signed [BLEND_W-1:0] NRM_MAX = 18'sd32767;
    localparam logic signed [BLEND_W-1:0] NRM_MIN = -18'sd32768;

    // Last step or corner index of each sequenced unit.
    localparam logic [STEP_W-1:0] CROSS_LAST  = 5'd6;
    localparam logic [STEP_W-1:0] SQUARE_LAST = 5'd4;
    localparam logic [STEP_W-1:0] SQRT_LAST   = 5'd31;
    localparam logic [STEP_W-1:0] FDIV_LAST   = 5'd16;
    localparam logic [STEP_W-1:0] BDIV_LAST   = 5'd16;
    localparam logic [1:0]        VTX_LAST    = 2'd2;

    typedef struct packed {
        logic        [IDX_W-1:0]   first_index;
        logic        [IDX_W-1:0]   second_index;
        logic        [IDX_W-1:0]   third_index;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
        logic signed [COORD_W-1:0] third_z;
    } in_t;

    typedef struct packed {
        logic        [IDX_W-1:0] vertex_index;
        logic signed [NRM_W-1:0] avg_x;
        logic signed [NRM_W-1:0] avg_y;
        logic signed [NRM_W-1:0] avg_z;
        logic                    degenerate;
        logic                    last_result;
    } out_t;

    // One word of the vertex store.
    typedef struct packed {
        logic        [CNT_W-1:0] count;
        logic signed [NRM_W-1:0] nz;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nx;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CROSS,
        ST_ABS,
        ST_NORM,
        ST_SQUARE,
        ST_SQRT,
        ST_FDIV,
        ST_READ,
        ST_LOAD,
        ST_BDIV,
        ST_WRITE
    } state_t;

endpackage

>>> rtl/vnra_ram.sv
// Generic simple dual-port RAM with a registered read port.
module vnra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/vertex_normal_running_average_top.sv
// Top level of the vertex normal running average block.
//
// One triangle item enters on the s_ channel: three vertex indices and three
// corner positions in signed Q16.16. The block forms the face normal, scales
// it to unit length in Q1.15 and blends it into the stored mean normal of each
// corner in turn. Three result items leave on the m_ channel, one per corner in
// the order first, second, third; last_result marks the third.
// A triangle passes in order through idle, the cross product on the shared
// multiplier, the magnitudes, the normalising shift, the sum of squares, the
// bit-pair square root and the face divide, and then through the store read,
// the rounding divide and the write back of each corner. A flat triangle
// skips the sum of squares, the root and the face divide. One triangle is
// worked on at a time; the next is accepted once the third result is in the
// output register. A stalled receiver holds the pipeline at the write of the
// following corner, and the store is not written until that result is taken.
// After reset the vertex store is swept to zero, one entry a cycle; s_ready
// stays low until the sweep ends.
`include "vertex_normal_running_average_top_macros.svh"

module vertex_normal_running_average_top
    import vnra_pkg::*;
#(
    parameter int VERTICES = 4096
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int AW = $clog2(VERTICES);

    // Control state.
    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        vtx_reg, vtx_next;
    logic [AW-1:0]     clr_addr_reg;
    logic              m_valid_reg;
    out_t              m_data_reg;

    // Triangle and arithmetic registers.
    logic        [IDX_W-1:0]    idx_reg   [3];
    logic signed [EDGE_W-1:0]   e1_reg    [3];
    logic signed [EDGE_W-1:0]   e2_reg    [3];
    logic signed [PROD_W-1:0]   mul_reg;
    logic signed [PROD_W-1:0]   hold_reg;
    logic signed [CROSS_W-1:0]  cross_reg [3];
    logic                       neg_reg   [3];
    logic        [CROSS_W-1:0]  mag_reg   [3];
    logic        [SQ_W-1:0]     sq_reg;
    logic        [SQ_W-1:0]     rad_reg;
    logic        [REM_W-1:0]    rem_reg;
    logic        [ROOT_W-1:0]   root_reg;
    logic        [FNUM_W-1:0]   fnum_reg  [3];
    logic        [FNUM_W-1:0]   fden_reg;
    logic        [FQ_W-1:0]     fq_reg    [3];
    logic signed [FACE_W-1:0]   face_reg  [3];
    logic                       degen_reg;
    logic        [CNT_W-1:0]    cnt_reg   [3];
    logic        [1:0]          occ_reg;
    logic signed [NRM_W-1:0]    old_reg   [3];
    logic        [BNUM_W-1:0]   bnum_reg  [3];
    logic        [BDEN_W-1:0]   bden_reg;
    logic        [BQ_W-1:0]     bq_reg    [3];
    logic                       bneg_reg  [3];

    // Combinational helpers.
    logic signed [EDGE_W-1:0]  mul_a, mul_b;
    logic        [CROSS_W-1:0] norm_w;
    logic        [STEP_W-1:0]  step_m1;
    logic        [ROOT_W+3:0]  sqrt_sh, sqrt_trial;
    logic                      out_free;
    logic                      load_out;
    logic        [AW-1:0]      addr_cur;
    logic                      in_range;
    logic                      ram_we;
    logic        [AW-1:0]      ram_waddr;
    entry_t                    ram_wdata;
    logic        [ENTRY_W-1:0] ram_rdata;
    entry_t                    rd_entry;
    logic signed [NRM_W-1:0]   rd_n      [3];
    logic        [CNT_W-1:0]   ld_cnt;
    logic        [1:0]         ld_occ;
    logic signed [NRM_W-1:0]   ld_old    [3];
    logic signed [BLEND_W-1:0] ld_d      [3];
    logic        [BQ_W-1:0]    ld_mag    [3];
    logic        [DIV_W-1:0]   ld_div;
    logic signed [BLEND_W-1:0] wr_sum    [3];
    logic signed [NRM_W-1:0]   wr_n      [3];
    logic        [CNT_W:0]     wr_cnt_sum;
    logic        [CNT_W-1:0]   wr_cnt;

    assign addr_cur = AW'(idx_reg[vtx_reg]);
    assign in_range = ({20'd0, idx_reg[vtx_reg]} < 32'(VERTICES));
    assign out_free = !m_valid_reg || m_ready;
    assign norm_w   = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign step_m1  = step_reg - 5'd1;
    assign rd_entry = entry_t'(ram_rdata);
    assign rd_n[0]  = rd_entry.nx;
    assign rd_n[1]  = rd_entry.ny;
    assign rd_n[2]  = rd_entry.nz;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    vnra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (VERTICES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_cur),
        .rdata (ram_rdata)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_SQUARE) begin
            unique case (step_reg[1:0])
                2'd0: mul_a = {3'b000, mag_reg[0][SCALED_W-1:0]};
                2'd1: mul_a = {3'b000, mag_reg[1][SCALED_W-1:0]};
                2'd2: mul_a = {3'b000, mag_reg[2][SCALED_W-1:0]};
                default: mul_a = '0;
            endcase
            mul_b = mul_a;
        end else begin
            unique case (step_reg[2:0])
                3'd0: begin mul_a = e1_reg[1]; mul_b = e2_reg[2]; end
                3'd1: begin mul_a = e1_reg[2]; mul_b = e2_reg[1]; end
                3'd2: begin mul_a = e1_reg[2]; mul_b = e2_reg[0]; end
                3'd3: begin mul_a = e1_reg[0]; mul_b = e2_reg[2]; end
                3'd4: begin mul_a = e1_reg[0]; mul_b = e2_reg[1]; end
                3'd5: begin mul_a = e1_reg[1]; mul_b = e2_reg[0]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    // Arithmetic for the square root, the store load and the write back.
    always_comb begin
        sqrt_sh    = {rem_reg, rad_reg[SQ_W-1:SQ_W-2]};
        sqrt_trial = {2'b00, root_reg, 2'b01};

        // Earlier corners of the same index supply the count from before the triangle.
        ld_occ = 2'd1;
        ld_cnt = rd_entry.count;
        if (vtx_reg == VTX_LAST && idx_reg[2] == idx_reg[1]) begin
            ld_cnt = cnt_reg[1];
            ld_occ = ld_occ + 2'd1;
        end
        if (vtx_reg != 2'd0 && idx_reg[vtx_reg] == idx_reg[0]) begin
            ld_cnt = cnt_reg[0];
            ld_occ = ld_occ + 2'd1;
        end
        if (!in_range) begin
            ld_cnt = '0;
        end
        ld_div = {1'b0, ld_cnt} + 17'd1;

        for (int c = 0; c < 3; c++) begin
            ld_old[c] = in_range ? rd_n[c] : '0;
            ld_d[c]   = {face_reg[c][FACE_W-1], face_reg[c]}
                        - {{2{ld_old[c][NRM_W-1]}}, ld_old[c]};
            ld_mag[c] = ld_d[c][BLEND_W-1] ? BQ_W'(-ld_d[c]) : BQ_W'(ld_d[c]);

            wr_sum[c] = bneg_reg[c]
                ? {{2{old_reg[c][NRM_W-1]}}, old_reg[c]} - $signed({1'b0, bq_reg[c]})
                : {{2{old_reg[c][NRM_W-1]}}, old_reg[c]} + $signed({1'b0, bq_reg[c]});
            if (wr_sum[c] > NRM_MAX) begin
                wr_n[c] = NRM_MAX[NRM_W-1:0];
            end else if (wr_sum[c] < NRM_MIN) begin
                wr_n[c] = NRM_MIN[NRM_W-1:0];
            end else begin
                wr_n[c] = wr_sum[c][NRM_W-1:0];
            end
        end

        wr_cnt_sum = {1'b0, cnt_reg[vtx_reg]} + {15'd0, occ_reg};
        wr_cnt     = wr_cnt_sum[CNT_W] ? CNT_MAX : wr_cnt_sum[CNT_W-1:0];
    end

    // Next state, step and corner counters.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg + 5'd1;
        vtx_next   = vtx_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == AW'(VERTICES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                step_next = '0;
                if (s_valid) begin
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS: begin
                if (step_reg == CROSS_LAST) begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS: begin
                state_next = ST_NORM;
            end
            ST_NORM: begin
                step_next = '0;
                vtx_next  = '0;
                if (norm_w == '0) begin
                    state_next = ST_READ;
                end else if (norm_w[CROSS_W-1:SCALED_W] == '0 && norm_w[SCALED_W-1]) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (step_reg == SQUARE_LAST) begin
                    state_next = ST_SQRT;
                    step_next  = '0;
                end
            end
            ST_SQRT: begin
                if (step_reg == SQRT_LAST) begin
                    state_next = ST_FDIV;
                    step_next  = '0;
                end
            end
            ST_FDIV: begin
                vtx_next = '0;
                if (step_reg == FDIV_LAST) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_BDIV;
                step_next  = '0;
            end
            ST_BDIV: begin
                if (step_reg == BDIV_LAST) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    if (vtx_reg == VTX_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                        vtx_next   = vtx_reg + 2'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and store write controls.
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        load_out  = (state_reg == ST_WRITE) && out_free;
        ram_we    = 1'b0;
        ram_waddr = addr_cur;
        ram_wdata = '{count: wr_cnt, nz: wr_n[2], ny: wr_n[1], nx: wr_n[0]};
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (load_out && in_range) begin
            ram_we = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            step_reg     <= '0;
            vtx_reg      <= '0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            vtx_reg   <= vtx_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        unique case (state_reg)
            ST_IDLE: begin
                idx_reg[0] <= s_data.first_index;
                idx_reg[1] <= s_data.second_index;
                idx_reg[2] <= s_data.third_index;
                e1_reg[0]  <= {s_data.second_x[COORD_W-1], s_data.second_x}
                              - {s_data.first_x[COORD_W-1], s_data.first_x};
                e1_reg[1]  <= {s_data.second_y[COORD_W-1], s_data.second_y}
                              - {s_data.first_y[COORD_W-1], s_data.first_y};
                e1_reg[2]  <= {s_data.second_z[COORD_W-1], s_data.second_z}
                              - {s_data.first_z[COORD_W-1], s_data.first_z};
                e2_reg[0]  <= {s_data.third_x[COORD_W-1], s_data.third_x}
                              - {s_data.first_x[COORD_W-1], s_data.first_x};
                e2_reg[1]  <= {s_data.third_y[COORD_W-1], s_data.third_y}
                              - {s_data.first_y[COORD_W-1], s_data.first_y};
                e2_reg[2]  <= {s_data.third_z[COORD_W-1], s_data.third_z}
                              - {s_data.first_z[COORD_W-1], s_data.first_z};
                degen_reg  <= 1'b0;
            end
            ST_CROSS: begin
                // Products are registered and used in the following step; pairs are differenced into each term.
                if (step_reg != '0) begin
                    if (!step_m1[0]) begin
                        hold_reg <= mul_reg;
                    end else begin
                        cross_reg[step_m1[2:1]] <= {hold_reg[PROD_W-1], hold_reg}
                                                   - {mul_reg[PROD_W-1], mul_reg};
                    end
                end
            end
            ST_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    neg_reg[i] <= cross_reg[i][CROSS_W-1];
                    mag_reg[i] <= cross_reg[i][CROSS_W-1] ? CROSS_W'(-cross_reg[i])
                                                          : CROSS_W'(cross_reg[i]);
                end
            end
            ST_NORM: begin
                // Bring the largest component to exactly 30 bits.
                sq_reg <= '0;
                if (norm_w == '0) begin
                    degen_reg <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        face_reg[i] <= '0;
                    end
                end else if (norm_w[CROSS_W-1:SCALED_W+8] != '0) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] >> 8;
                    end
                end else if (norm_w[CROSS_W-1:SCALED_W] != '0) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end else if (!norm_w[SCALED_W-1]) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= (norm_w[SCALED_W-1:SCALED_W-9] == '0)
                                      ? mag_reg[i] << 8 : mag_reg[i] << 1;
                    end
                end
            end
            ST_SQUARE: begin
                if (step_reg != '0 && step_reg != SQUARE_LAST) begin
                    sq_reg <= sq_reg + mul_reg[SQ_W-1:0];
                end
                rad_reg  <= sq_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            ST_SQRT: begin
                // One root bit per cycle from two radicand bits.
                if (step_reg == SQRT_LAST) begin
                    fden_reg <= {root_reg, 16'd0};
                    for (int i = 0; i < 3; i++) begin
                        fnum_reg[i] <= {1'b0, mag_reg[i][SCALED_W-1:0], 16'd0}
                                       + {16'd0, root_reg};
                        fq_reg[i]   <= '0;
                    end
                end else begin
                    rad_reg <= rad_reg << 2;
                    if (sqrt_sh >= sqrt_trial) begin
                        rem_reg  <= REM_W'(sqrt_sh - sqrt_trial);
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= sqrt_sh[REM_W-1:0];
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                end
            end
            ST_FDIV: begin
                // Restoring divide of the three scaled components by twice the norm.
                if (step_reg == FDIV_LAST) begin
                    for (int i = 0; i < 3; i++) begin
                        face_reg[i] <= neg_reg[i] ? -$signed({1'b0, fq_reg[i]})
                                                  : $signed({1'b0, fq_reg[i]});
                    end
                end else begin
                    fden_reg <= fden_reg >> 1;
                    for (int i = 0; i < 3; i++) begin
                        if (fnum_reg[i] >= fden_reg) begin
                            fnum_reg[i] <= fnum_reg[i] - fden_reg;
                            fq_reg[i]   <= {fq_reg[i][FQ_W-2:0], 1'b1};
                        end else begin
                            fq_reg[i]   <= {fq_reg[i][FQ_W-2:0], 1'b0};
                        end
                    end
                end
            end
            ST_LOAD: begin
                cnt_reg[vtx_reg] <= ld_cnt;
                occ_reg          <= ld_occ;
                bden_reg         <= {ld_div, 17'd0};
                for (int c = 0; c < 3; c++) begin
                    old_reg[c]  <= ld_old[c];
                    bneg_reg[c] <= ld_d[c][BLEND_W-1];
                    bnum_reg[c] <= {ld_mag[c], 1'b0} + {1'b0, ld_div};
                    bq_reg[c]   <= '0;
                end
            end
            ST_BDIV: begin
                // Rounded quotient of the difference by one more than the count from before the triangle.
                bden_reg <= bden_reg >> 1;
                for (int c = 0; c < 3; c++) begin
                    if ({16'd0, bnum_reg[c]} >= bden_reg) begin
                        bnum_reg[c] <= BNUM_W'({16'd0, bnum_reg[c]} - bden_reg);
                        bq_reg[c]   <= {bq_reg[c][BQ_W-2:0], 1'b1};
                    end else begin
                        bq_reg[c]   <= {bq_reg[c][BQ_W-2:0], 1'b0};
                    end
                end
            end
            default: begin
            end
        endcase

        // Output register.
        if (load_out) begin
            m_data_reg <= '{vertex_index: idx_reg[vtx_reg],
                            avg_x:        wr_n[0],
                            avg_y:        wr_n[1],
                            avg_z:        wr_n[2],
                            degenerate:   degen_reg,
                            last_result:  (vtx_reg == VTX_LAST)};
        end
    end

    `VNRA_ASSERT_NOW(a_no_overwrite, aclk, aresetn, load_out, out_free, "result item overwritten")
    `VNRA_ASSERT_NEXT(a_third_ends, aclk, aresetn, load_out && vtx_reg == VTX_LAST, state_reg == ST_IDLE, "triangle did not end after third item")
    `VNRA_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state_reg == ST_CROSS, "accepted item did not start")
    `VNRA_ASSERT_NOW(a_clear_quiet, aclk, aresetn, state_reg == ST_CLEAR, !m_valid_reg && !s_ready, "activity during store clear")

endmodule
